[design/pmst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types and codes of the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_RUN   = 1'b1;

	localparam logic [1:0] STATUS_EDGE   = 2'd0;
	localparam logic [1:0] STATUS_DISCON = 2'd1;
	localparam logic [1:0] STATUS_SINGLE = 2'd2;

	localparam logic       REG_NODE_COUNT = 1'b0;
	localparam logic [4:0] NODE_COUNT_RST = 5'd16;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  node_a;
		logic [3:0]  node_b;
		logic [15:0] weight;
		logic [3:0]  start_node;
	} item_t;

	typedef struct packed {
		logic [3:0]  from_node;
		logic [3:0]  to_node;
		logic [15:0] edge_weight;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic clear;
		logic mark;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR2,
		ST_SCAN,
		ST_EMIT
	} pmst_state_t;

endpackage
`default_nettype wire

[design/pmst_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module pmst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[design/pmst_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_cell
// One node of the chain: holds key, parent and tree bit, relaxes its key with
// the row weight and hands the running best candidate to the next cell.
// ----------------------------------------------------------------------------
module pmst_cell
	import pmst_pkg::*;
#(
	parameter int MAX_NODES   = 16,
	parameter int WEIGHT_BITS = 16,
	parameter int IDX         = 0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cell_ctl_t                      ctl,
	input  wire logic [$clog2(MAX_NODES)-1:0]   mark_idx,
	input  wire logic [$clog2(MAX_NODES)-1:0]   u,
	input  wire logic [$clog2(MAX_NODES+1)-1:0] n,
	input  wire logic [WEIGHT_BITS-1:0]         wt,
	input  wire logic                           tin_act,
	input  wire logic [WEIGHT_BITS:0]           tin_key,
	input  wire logic [$clog2(MAX_NODES)-1:0]   tin_idx,
	input  wire logic [$clog2(MAX_NODES)-1:0]   tin_par,
	output logic                                tout_act,
	output logic      [WEIGHT_BITS:0]           tout_key,
	output logic      [$clog2(MAX_NODES)-1:0]   tout_idx,
	output logic      [$clog2(MAX_NODES)-1:0]   tout_par
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int KW = WEIGHT_BITS + 1;
	localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [IW-1:0] MY_IDX  = IW'(IDX);

	logic          in_tree_q;
	logic [KW-1:0] key_q;
	logic [IW-1:0] par_q;
	logic          in_use;
	logic          take;
	logic          better;
	logic [KW-1:0] new_key;
	logic [IW-1:0] new_par;

	always_comb begin
		in_use  = CW'(IDX) < n;
		take    = tin_act && !in_tree_q && in_use && (wt != '0) && ({1'b0, wt} < key_q);
		new_key = take ? {1'b0, wt} : key_q;
		new_par = take ? u : par_q;
		// strict compare so the lower index already on the chain keeps a tie
		better  = tin_act && !in_tree_q && in_use && (new_key < tin_key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tree_q <= 1'b0;
			key_q     <= KEY_INF;
			tout_act  <= 1'b0;
		end else begin
			tout_act <= tin_act;
			if (ctl.clear) begin
				in_tree_q <= ctl.mark && (mark_idx == MY_IDX);
				key_q     <= KEY_INF;
			end else begin
				if (ctl.mark && (mark_idx == MY_IDX)) begin
					in_tree_q <= 1'b1;
				end
				if (take) begin
					key_q <= new_key;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctl.clear) begin
			par_q <= new_par;
		end
		tout_key <= better ? new_key : tin_key;
		tout_idx <= better ? MY_IDX : tin_idx;
		tout_par <= better ? new_par : tin_par;
	end

endmodule
`default_nettype wire

[design/prim_minimum_spanning_tree.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim spanning tree engine over an adjacency matrix held in RAM.
// ----------------------------------------------------------------------------
// item beats carry a command: a write stores one weight in both symmetric
// matrix entries, one after the other; a run grows the tree from start_node
// over the first node_count nodes (APB register 0).
// each step reads one matrix row, one entry a cycle, while a token runs down
// a chain of MAX_NODES cells that relax their keys and pick the cheapest node;
// a run is paced by the row read port and the chain.
// one result beat per tree edge, or one status beat, the last flagged.
// after reset a clearing pass writes zero to the whole matrix, during which
// no item is taken; register writes are always taken.
// results go through a single output register; while it is full and result_stall
// is high the run waits, and a new item is taken as soon as the run is finished.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree
	import pmst_pkg::*;
#(
	parameter int MAX_NODES   = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IW    = $clog2(MAX_NODES);
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int KW    = WEIGHT_BITS + 1;
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [KW-1:0] KEY_INF  = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
	localparam logic [IW-1:0] K_LAST   = IW'(MAX_NODES - 1);

	pmst_state_t       state_q, state_d;
	logic [4:0]        node_count_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     wr2_addr_q;
	logic [WEIGHT_BITS-1:0] wr_w_q;
	logic [IW-1:0]     u_q;
	logic [IW-1:0]     k_q;
	logic              rd_on_q;
	logic              tok0_q;
	logic [CW-1:0]     steps_q;
	logic [CW-1:0]     n_q;
	result_t           res_q;
	logic              res_done_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              item_acc;
	logic              cfg_wr;
	logic [CW-1:0]     n_eff;
	logic              start_ok;
	logic              wr_ok;
	logic [AW-1:0]     addr_ab;
	logic [AW-1:0]     addr_ba;
	logic [AW-1:0]     addr_rd;
	logic              out_free;
	logic              scan_done;
	logic              found;
	logic              is_last;

	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic [WEIGHT_BITS-1:0] ram_rdata;
	cell_ctl_t              ctl;
	logic [IW-1:0]          mark_idx;

	logic          tok_act [MAX_NODES+1];
	logic [KW-1:0] tok_key [MAX_NODES+1];
	logic [IW-1:0] tok_idx [MAX_NODES+1];
	logic [IW-1:0] tok_par [MAX_NODES+1];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {27'b0, node_count_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[4:0];
		end
	end

	always_comb begin
		if (node_count_q == 5'd0) begin
			n_eff = CW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_eff = CW'(MAX_NODES);
		end else begin
			n_eff = CW'(node_count_q);
		end
		start_ok  = 32'(item.start_node) < 32'(n_eff);
		wr_ok     = (32'(item.node_a) < MAX_NODES) && (32'(item.node_b) < MAX_NODES);
		addr_ab   = AW'(AW'(item.node_a) * AW'(MAX_NODES) + AW'(item.node_b));
		addr_ba   = AW'(AW'(item.node_b) * AW'(MAX_NODES) + AW'(item.node_a));
		addr_rd   = AW'(AW'(u_q) * AW'(MAX_NODES) + AW'(k_q));
		item_acc  = item_valid && !item_stall;
		out_free  = !out_valid_q || !result_stall;
		scan_done = tok_act[MAX_NODES];
		found     = tok_key[MAX_NODES] != KEY_INF;
		is_last   = (steps_q + CW'(1)) == (n_q - CW'(1));
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_acc) begin
					if (item.cmd == CMD_WRITE) begin
						if (wr_ok) state_d = ST_WR2;
					end else if (n_eff == CW'(1) || !start_ok) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_WR2: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = res_done_q ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_rd;
		ram_wdata = wr_w_q;
		ctl       = '0;
		mark_idx  = tok_idx[MAX_NODES];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_addr  = addr_ab;
				ram_wdata = WEIGHT_BITS'(item.weight);
				ram_we    = item_acc && (item.cmd == CMD_WRITE) && wr_ok;
				if (item_acc && (item.cmd == CMD_RUN) && (n_eff != CW'(1)) && start_ok) begin
					ctl.clear = 1'b1;
					ctl.mark  = 1'b1;
					mark_idx  = IW'(item.start_node);
				end
			end
			ST_WR2: begin
				ram_we   = 1'b1;
				ram_addr = wr2_addr_q;
			end
			ST_SCAN: begin
				ctl.mark = scan_done && found;
			end
			ST_EMIT: begin
				ctl = '0;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_on_q     <= 1'b0;
			tok0_q      <= 1'b0;
			out_valid_q <= 1'b0;
			res_done_q  <= 1'b0;
			steps_q     <= '0;
			n_q         <= '0;
			k_q         <= '0;
			u_q         <= '0;
		end else begin
			state_q <= state_d;
			tok0_q  <= (state_q == ST_SCAN) && rd_on_q && (k_q == '0);
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (item_acc && (item.cmd == CMD_RUN)) begin
						n_q     <= n_eff;
						steps_q <= '0;
						u_q     <= IW'(item.start_node);
						k_q     <= '0;
						if (n_eff == CW'(1) || !start_ok) begin
							res_done_q <= 1'b1;
						end else begin
							res_done_q <= 1'b0;
							rd_on_q    <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (rd_on_q) begin
						k_q <= k_q + IW'(1);
						if (k_q == K_LAST) rd_on_q <= 1'b0;
					end
					if (scan_done) begin
						res_done_q <= !found || is_last;
						u_q        <= tok_idx[MAX_NODES];
						steps_q    <= steps_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (out_free && !res_done_q) begin
						rd_on_q <= 1'b1;
						k_q     <= '0;
					end
				end
				default: begin
					rd_on_q <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_acc) begin
			wr2_addr_q <= addr_ba;
			wr_w_q     <= WEIGHT_BITS'(item.weight);
			res_q.from_node   <= 4'd0;
			res_q.to_node     <= 4'd0;
			res_q.edge_weight <= 16'd0;
			res_q.status      <= (n_eff == CW'(1)) ? STATUS_SINGLE : STATUS_DISCON;
			res_q.last        <= 1'b1;
		end
		if (state_q == ST_SCAN && scan_done) begin
			if (found) begin
				res_q.from_node   <= 4'(tok_par[MAX_NODES]);
				res_q.to_node     <= 4'(tok_idx[MAX_NODES]);
				res_q.edge_weight <= 16'(tok_key[MAX_NODES]);
				res_q.status      <= STATUS_EDGE;
				res_q.last        <= is_last;
			end else begin
				res_q.from_node   <= 4'd0;
				res_q.to_node     <= 4'd0;
				res_q.edge_weight <= 16'd0;
				res_q.status      <= STATUS_DISCON;
				res_q.last        <= 1'b1;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	pmst_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_matrix (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// token enters the chain as the first row entry leaves the ram
	assign tok_act[0] = tok0_q;
	assign tok_key[0] = KEY_INF;
	assign tok_idx[0] = '0;
	assign tok_par[0] = '0;

	for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
		pmst_cell #(
			.MAX_NODES   (MAX_NODES),
			.WEIGHT_BITS (WEIGHT_BITS),
			.IDX         (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.mark_idx (mark_idx),
			.u        (u_q),
			.n        (n_q),
			.wt       (ram_rdata),
			.tin_act  (tok_act[i]),
			.tin_key  (tok_key[i]),
			.tin_idx  (tok_idx[i]),
			.tin_par  (tok_par[i]),
			.tout_act (tok_act[i+1]),
			.tout_key (tok_key[i+1]),
			.tout_idx (tok_idx[i+1]),
			.tout_par (tok_par[i+1])
		);
	end

endmodule
`default_nettype wire
